// File: rtl/message_flood_rate_limiter_core_assert.svh
`ifndef MESSAGE_FLOOD_RATE_LIMITER_CORE_ASSERT_SVH
`define MESSAGE_FLOOD_RATE_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MFRL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfrl assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MFRL_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfrl assertion failed");

`endif

// File: rtl/mfrl_pkg.sv
package mfrl_pkg;

  // Hash index offset, clock slack for backward steps, highest mode for repeat check
  localparam logic [31:0] HASH_OFFSET     = 32'h004E_C691;
  localparam logic [31:0] CLOCK_SLACK     = 32'd10;
  localparam logic [1:0]  REPEAT_MODE_MAX = 2'd1;

  // Register reset values
  localparam logic [15:0] CREDIT_RESET = 16'd2000;
  localparam logic [15:0] LIMIT_RESET  = 16'd6000;

  // Register indexes on the configuration channel
  typedef enum logic [1:0] {
    REG_MUTE   = 2'd0,
    REG_CREDIT = 2'd1,
    REG_LIMIT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic        mute;
    logic [15:0] credit;
    logic [15:0] limit;
  } cfg_t;

  // Finished message handed from the hash stage to the decision stage
  typedef struct packed {
    logic [31:0] hash;
    logic [1:0]  mode;
    logic [31:0] now;
  } msg_t;

  // Decision state visible to the top level
  typedef struct packed {
    logic blocked;
    logic timer_zero;
  } sts_t;

endpackage

// File: rtl/mfrl_hash.sv
module mfrl_hash (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        char_byte,
  input  logic              last_char,
  input  logic [1:0]        chat_mode,
  input  logic [31:0]       now_ms,
  output logic              msg_valid,
  output mfrl_pkg::msg_t    msg,
  input  logic              msg_ready
);

  logic        in_full;
  logic [7:0]  in_char;
  logic        in_last;
  logic [1:0]  in_mode;
  logic [31:0] in_now;

  logic [31:0] running_hash;
  logic [31:0] char_index;

  logic [31:0] char_ext;
  logic [31:0] product;
  logic [31:0] hash_next;
  logic        msg_free;
  logic        in_adv;

  // Fold the registered character into the running hash
  assign char_ext  = {{24{in_char[7]}}, in_char};
  assign product   = char_ext * (char_index + mfrl_pkg::HASH_OFFSET);
  assign hash_next = running_hash + product;

  // Non-last characters never wait; a last character waits for a free message slot
  assign msg_free = !msg_valid || msg_ready;
  assign in_adv   = in_full && (!in_last || msg_free);
  assign in_ready = !in_full || in_adv;

  // Control and accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      msg_valid    <= 1'b0;
      running_hash <= '0;
      char_index   <= '0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (in_adv) begin
        if (in_last) begin
          running_hash <= '0;
          char_index   <= '0;
        end else begin
          running_hash <= hash_next;
          char_index   <= char_index + 32'd1;
        end
      end
      if (msg_free) begin
        msg_valid <= in_adv && in_last;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char <= char_byte;
      in_last <= last_char;
      in_mode <= chat_mode;
      in_now  <= now_ms;
    end
    if (in_adv && in_last) begin
      msg.hash <= hash_next;
      msg.mode <= in_mode;
      msg.now  <= in_now;
    end
  end

endmodule

// File: rtl/mfrl_decide.sv
module mfrl_decide (
  input  logic              clk,
  input  logic              rst,
  input  mfrl_pkg::cfg_t    cfg,
  input  logic              msg_valid,
  input  mfrl_pkg::msg_t    msg,
  output logic              msg_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              accepted,
  output mfrl_pkg::sts_t    sts
);

  logic [31:0] last_clock;
  logic [31:0] credit_timer;
  logic        blocked_flag;
  logic [31:0] previous_hash;
  logic [1:0]  previous_mode;

  logic [31:0] last_clock_next;
  logic [31:0] credit_timer_next;
  logic        blocked_flag_next;
  logic [31:0] previous_hash_next;
  logic [1:0]  previous_mode_next;
  logic        verdict;

  logic        take;
  logic [31:0] back_step;
  logic [31:0] now_eff;
  logic [31:0] elapsed;
  logic        drain_hit;
  logic [31:0] timer_drained;
  logic        blocked_drained;
  logic        rep_hit;
  logic [31:0] credit_ext;
  logic [31:0] timer_credited;
  logic        over_limit;

  assign msg_ready = !out_valid || out_ready;
  assign take      = msg_valid && msg_ready;

  assign sts.blocked    = blocked_flag;
  assign sts.timer_zero = (credit_timer == 32'd0);

  // Clamp small backward clock steps, then drain the timer
  assign back_step       = last_clock - msg.now;
  assign now_eff         = (back_step < mfrl_pkg::CLOCK_SLACK) ? last_clock : msg.now;
  assign elapsed         = now_eff - last_clock;
  assign drain_hit       = credit_timer > elapsed;
  assign timer_drained   = drain_hit ? (credit_timer - elapsed) : 32'd0;
  assign blocked_drained = drain_hit && blocked_flag;

  // Repeat of the previous message at the same or lower mode
  assign rep_hit = (msg.hash == previous_hash) && (previous_mode >= msg.mode) &&
                   (msg.mode <= mfrl_pkg::REPEAT_MODE_MAX) && (timer_drained != 32'd0);

  assign credit_ext     = {16'd0, cfg.credit};
  assign timer_credited = timer_drained + credit_ext;
  assign over_limit     = timer_credited > {16'd0, cfg.limit};

  // Decide and work out the next limiter state
  always_comb begin
    last_clock_next    = last_clock;
    credit_timer_next  = credit_timer;
    blocked_flag_next  = blocked_flag;
    previous_hash_next = previous_hash;
    previous_mode_next = previous_mode;
    verdict            = 1'b0;
    if (!cfg.mute) begin
      last_clock_next   = now_eff;
      credit_timer_next = timer_drained;
      blocked_flag_next = blocked_drained;
      if (!blocked_drained && !rep_hit) begin
        previous_hash_next = msg.hash;
        previous_mode_next = msg.mode;
        if (over_limit) begin
          credit_timer_next = timer_credited + credit_ext;
          blocked_flag_next = 1'b1;
        end else begin
          credit_timer_next = timer_credited;
          verdict           = 1'b1;
        end
      end
    end
  end

  // Limiter state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      last_clock    <= '0;
      credit_timer  <= '0;
      blocked_flag  <= 1'b0;
      previous_hash <= '0;
      previous_mode <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        last_clock    <= last_clock_next;
        credit_timer  <= credit_timer_next;
        blocked_flag  <= blocked_flag_next;
        previous_hash <= previous_hash_next;
        previous_mode <= previous_mode_next;
      end
      if (msg_ready) begin
        out_valid <= msg_valid;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      accepted <= verdict;
    end
  end

endmodule

// File: rtl/message_flood_rate_limiter_core.sv
// Channel   Direction  Signals                          Contents
// s_axis    in         tvalid tready tdata tlast tuser  one message character per transfer
// m_axis    out        tvalid tready tdata              one verdict per message
// cfg       in         valid ready index data           register writes
//
// One character transfer per cycle is sustained, back-to-back messages included,
// while m_axis is not stalled. A verdict becomes valid once the last character has
// passed the input register, then the message register, then the result register.
// The rate is set by the timer update in the decision stage, registered on each take.
// Reset clears the hash, the limiter state and loads register defaults.
// A stalled m_axis holds its verdict and backs up into s_axis one stage at a time.
`include "message_flood_rate_limiter_core_assert.svh"

module message_flood_rate_limiter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] char_byte, [39:8] now_ms
  input  logic        s_axis_tlast,   // last_char
  input  logic [1:0]  s_axis_tuser,   // [1:0] chat_mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] accepted, [7:1] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  mfrl_pkg::cfg_t cfg;
  logic           msg_valid;
  logic           msg_ready;
  mfrl_pkg::msg_t msg;
  logic           accepted;
  mfrl_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mute   <= 1'b0;
      cfg.credit <= mfrl_pkg::CREDIT_RESET;
      cfg.limit  <= mfrl_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mfrl_pkg::REG_MUTE:   cfg.mute   <= cfg_data[0];
        mfrl_pkg::REG_CREDIT: cfg.credit <= cfg_data;
        mfrl_pkg::REG_LIMIT:  cfg.limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  mfrl_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .char_byte (s_axis_tdata[7:0]),
    .last_char (s_axis_tlast),
    .chat_mode (s_axis_tuser),
    .now_ms    (s_axis_tdata[39:8]),
    .msg_valid (msg_valid),
    .msg       (msg),
    .msg_ready (msg_ready)
  );

  mfrl_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .msg_valid (msg_valid),
    .msg       (msg),
    .msg_ready (msg_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .accepted  (accepted),
    .sts       (sts)
  );

  assign m_axis_tdata = {7'd0, accepted};

  // A held verdict keeps the decision stage from consuming a message
  `MFRL_ASSERT_IMP(a_hold_blocks_take, clk, rst,
    msg_valid && m_axis_tvalid && !m_axis_tready, !msg_ready)
  // A muted decision always rejects
  `MFRL_ASSERT_NXT(a_mute_rejects, clk, rst,
    msg_valid && msg_ready && cfg.mute, m_axis_tvalid && !m_axis_tdata[0])
  // An accepted message never leaves the sender blocked
  `MFRL_ASSERT_IMP(a_accept_unblocked, clk, rst,
    m_axis_tvalid && m_axis_tdata[0], !sts.blocked)
  // A blocked sender always has credit left to drain
  `MFRL_ASSERT_IMP(a_blocked_has_credit, clk, rst, sts.blocked, !sts.timer_zero)

endmodule

// File: tb/mfrl_verdict_checker.sv
`timescale 1ns / 100ps

// Watch the character, verdict and register channels, predict each verdict
// from the characters and settings seen, and compare in order.
module mfrl_verdict_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] char_byte, [39:8] now_ms
  input  logic        s_axis_tlast,   // last_char
  input  logic [1:0]  s_axis_tuser,   // [1:0] chat_mode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [0] accepted, [7:1] zero
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int REPORT_MAX = 10;

  // Shadow of the register file
  logic        mute_q;
  logic [15:0] credit_q;
  logic [15:0] limit_q;

  // Shadow of the hash and limiter state
  logic [31:0] hash_acc;
  logic [31:0] char_pos;
  logic [31:0] clock_seen;
  logic [31:0] credit_timer;
  logic [31:0] prev_hash;
  logic [1:0]  prev_mode;
  logic        blocked;

  // Verdicts predicted but not yet seen on m_axis
  logic        verdict_q[$];

  // Decide one finished message and advance the limiter state
  function automatic logic judge_message(input logic [31:0] msg_hash,
                                         input logic [1:0]  mode,
                                         input logic [31:0] now);
    logic [31:0] stamp;
    logic [31:0] elapsed;
    if (mute_q) return 1'b0;
    // Treat a small backward clock step as no time passed
    stamp = now;
    if ((clock_seen - stamp) < mfrl_pkg::CLOCK_SLACK) stamp = clock_seen;
    elapsed = stamp - clock_seen;
    // Drain the bucket; an empty bucket releases the sender
    if (credit_timer > elapsed) begin
      credit_timer = credit_timer - elapsed;
    end else begin
      credit_timer = '0;
      blocked = 1'b0;
    end
    clock_seen = stamp;
    if (blocked) return 1'b0;
    // Drop a repeat at the same or a lower mode while credit is pending
    if (msg_hash == prev_hash && prev_mode >= mode && mode <= mfrl_pkg::REPEAT_MODE_MAX &&
        credit_timer != '0) return 1'b0;
    prev_hash = msg_hash;
    prev_mode = mode;
    credit_timer = credit_timer + 32'(credit_q);
    // Overflowing the limit costs a second credit and blocks the sender
    if (credit_timer > 32'(limit_q)) begin
      credit_timer = credit_timer + 32'(credit_q);
      blocked = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    logic [31:0] ch;
    logic [31:0] sum;
    logic        want;
    if (rst) begin
      mute_q       = 1'b0;
      credit_q     = mfrl_pkg::CREDIT_RESET;
      limit_q      = mfrl_pkg::LIMIT_RESET;
      hash_acc     = '0;
      char_pos     = '0;
      clock_seen   = '0;
      credit_timer = '0;
      prev_hash    = '0;
      prev_mode    = '0;
      blocked      = 1'b0;
      verdict_q.delete();
      fail_count   = 0;
      pending      = 0;
    end else begin
      // Compare each verdict transfer with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: unexpected verdict transfer, tdata=%02h", $realtime, m_axis_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata !== {7'b0, want}) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%0t: verdict mismatch, expected tdata=%02h, actual tdata=%02h",
                       $realtime, {7'b0, want}, m_axis_tdata);
          end
        end
      end

      // Track register writes; unknown indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (mfrl_pkg::cfg_reg_t'(cfg_index))
          mfrl_pkg::REG_MUTE:   mute_q   = cfg_data[0];
          mfrl_pkg::REG_CREDIT: credit_q = cfg_data;
          mfrl_pkg::REG_LIMIT:  limit_q  = cfg_data;
          default: ;
        endcase
      end

      // Fold each character into the hash; decide on the last one
      if (s_axis_tvalid && s_axis_tready) begin
        ch  = {{24{s_axis_tdata[7]}}, s_axis_tdata[7:0]};
        sum = hash_acc + ch * (char_pos + mfrl_pkg::HASH_OFFSET);
        if (s_axis_tlast) begin
          hash_acc = '0;
          char_pos = '0;
          verdict_q.push_back(judge_message(sum, s_axis_tuser, s_axis_tdata[39:8]));
        end else begin
          hash_acc = sum;
          char_pos = char_pos + 32'd1;
        end
      end

      pending = verdict_q.size();
    end
  end

endmodule

// File: tb/tb_message_flood_rate_limiter_core.sv
`timescale 1ns / 100ps

module tb_message_flood_rate_limiter_core;

  localparam logic [1:0] REG_SPARE     = 2'd3;   // index with no register behind it
  localparam int         SETTLE_CYCLES = 8;
  localparam int         PHASES        = 8;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // [7:0] char_byte, [39:8] now_ms
  logic        s_axis_tlast  = 1'b0; // last_char
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] chat_mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [0] accepted, [7:1] zero
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index     = '0;
  logic [15:0] cfg_data      = '0;

  int          fail_count;
  int          pending;

  logic        calm      = 1'b0;     // no gaps on either side while set
  int          items_sent = 0;
  int          credit_cur = 2000;
  logic [31:0] wall      = '0;       // millisecond clock carried by last characters
  logic [7:0]  msg_text[$];

  message_flood_rate_limiter_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  mfrl_verdict_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Stall the verdict side at random
  initial begin
    int g;
    forever begin
      g = pick_gap();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Move one character; valid stays high for a back-to-back follower
  task automatic send_char(input logic [7:0] ch, input logic last,
                           input logic [1:0] mode, input logic [31:0] now);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, ch};
    s_axis_tlast  <= last;
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // Send msg_text; only the last character carries a meaningful mode and clock
  task automatic send_message(input logic [1:0] mode, input logic [31:0] now);
    for (int i = 0; i < msg_text.size(); i++) begin
      if (i == msg_text.size() - 1)
        send_char(msg_text[i], 1'b1, mode, now);
      else
        send_char(msg_text[i], 1'b0, 2'($urandom_range(0, 3)), $urandom);
    end
  endtask

  // Hold off until every verdict is back and the pipeline has emptied
  task automatic wait_for_verdicts();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_settings(input logic mute, input logic [15:0] credit,
                                input logic [15:0] limit);
    wait_for_verdicts();
    write_reg(mfrl_pkg::REG_MUTE, {15'($urandom), mute});
    write_reg(mfrl_pkg::REG_CREDIT, credit);
    write_reg(mfrl_pkg::REG_LIMIT, limit);
    write_reg(REG_SPARE, 16'($urandom));
    cfg_valid  <= 1'b0;
    credit_cur = int'(credit);
  endtask

  // Advance the message clock: mostly forward, sometimes back or far away
  function automatic logic [31:0] next_now();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)      wall = wall + 32'($urandom_range(0, 2 * credit_cur + 20));
    else if (r < 75) wall = wall;
    else if (r < 85) wall = wall - 32'($urandom_range(1, 9));
    else if (r < 92) wall = wall - 32'($urandom_range(10, 1000));
    else             wall = $urandom;
    return wall;
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'h00;
    if (r < 30) begin
      case ($urandom_range(0, 3))
        0:       return 8'h80;
        1:       return 8'h7F;
        2:       return 8'hFF;
        default: return 8'h01;
      endcase
    end
    return 8'($urandom);
  endfunction

  // Build the next message: repeat the last text, send an empty one, or a fresh one
  task automatic make_text();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 30 && msg_text.size() > 0) return;
    msg_text.delete();
    if (r < 40) begin
      msg_text.push_back(8'h00);
      return;
    end
    len = (r >= 95) ? $urandom_range(16, 40) : $urandom_range(1, 8);
    repeat (len) msg_text.push_back(pick_char());
  endtask

  function automatic int phase_items(input int ph);
    case (ph)
      0:       return 80;
      1:       return 15;
      2:       return 40;
      3:       return 60;
      4:       return 30;
      5:       return 30;
      6:       return 60;
      default: return 85;
    endcase
  endfunction

  initial begin
    int target;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty messages, repeats by mode, byte extremes, clock steps, blocking
    msg_text = '{8'h00};
    send_message(2'd0, 32'd0);
    send_message(2'd0, 32'd5);
    send_message(2'd2, 32'd5);
    send_message(2'd1, 32'd5);
    msg_text = '{8'h80, 8'h7F, 8'hFF, 8'h00, 8'h01};
    send_message(2'd3, 32'd1);
    msg_text = '{8'h41, 8'h42};
    send_message(2'd0, 32'd2);
    msg_text = '{8'h55};
    send_message(2'd0, 32'hFFFF_FFF0);
    send_message(2'd0, 32'h0000_0010);
    msg_text = '{8'hFF, 8'h00, 8'h80, 8'h00, 8'h7F, 8'hAA, 8'h55, 8'h00};
    send_message(2'd1, 32'h0000_0020);
    wall = 32'h0000_0020;

    // Random: one setting per phase, extremes first
    for (int ph = 0; ph < PHASES; ph++) begin
      calm = 1'b0;
      case (ph)
        0:       apply_settings(1'b0, mfrl_pkg::CREDIT_RESET, mfrl_pkg::LIMIT_RESET);
        1:       apply_settings(1'b1, mfrl_pkg::CREDIT_RESET, mfrl_pkg::LIMIT_RESET);
        2:       apply_settings(1'b0, 16'd0, 16'd0);
        3:       apply_settings(1'b0, 16'hFFFF, 16'hFFFF);
        4:       apply_settings(1'b0, 16'hFFFF, 16'd0);
        5:       apply_settings(1'b0, 16'd0, 16'hFFFF);
        6:       apply_settings(1'b0, 16'($urandom_range(1, 4000)),
                                16'($urandom_range(0, 12000)));
        default: apply_settings(1'b0, 16'($urandom), 16'($urandom));
      endcase
      calm = (ph == 6);
      target = items_sent + phase_items(ph);
      while (items_sent < target) begin
        make_text();
        send_message(2'($urandom_range(0, 3)), next_now());
        if ($urandom_range(0, 29) == 0) wait_for_verdicts();
      end
    end

    calm = 1'b0;
    wait_for_verdicts();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
